// ===== src/sbrs_pkg.sv =====
package sbrs_pkg;

  // Map geometry
  localparam int MAP_BYTES  = 32;
  localparam int MAP_POINTS = MAP_BYTES * 8;
  localparam int BYTE_AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  // Command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_MARK   = 2'd1;
  localparam logic [1:0] CMD_SELECT = 2'd2;
  localparam logic [1:0] CMD_RANK   = 2'd3;

  localparam logic [7:0] NO_POINT = 8'hff;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] point;
    logic [7:0] nth;
    logic [7:0] current_rank;
  } in_beat_t;

  typedef struct packed {
    logic       found;
    logic [7:0] point_index;
    logic [7:0] rank;
    logic [7:0] total;
  } out_beat_t;

  // Per-byte results of the shared byte unit
  typedef struct packed {
    logic [3:0] pop;       // set bits in the byte
    logic [3:0] pop_low;   // set bits at or below bit_pos
    logic       bit_set;   // bit at bit_pos
    logic [2:0] sel_pos;   // position of the k-th set bit
  } byte_res_t;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

  // Position of the k-th set bit (k from 1), scanning upward
  function automatic logic [2:0] select8(input logic [7:0] b, input logic [3:0] k);
    logic [3:0] seen;
    logic [2:0] pos;
    logic       hit;
    seen = 4'd0;
    pos  = 3'd0;
    hit  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        seen = seen + 4'd1;
        if (!hit && seen == k) begin
          pos = 3'(i);
          hit = 1'b1;
        end
      end
    end
    return pos;
  endfunction

endpackage

// ===== src/sbrs_byte_unit.sv =====
module sbrs_byte_unit (
  input  logic              [7:0] byte_data,
  input  logic              [2:0] bit_pos,
  input  logic              [3:0] k,
  output sbrs_pkg::byte_res_t     res
);

  logic [7:0] low_mask;

  // bits 0..bit_pos inclusive
  assign low_mask = 8'((9'd2 << bit_pos) - 9'd1);

  always_comb begin
    res.pop     = sbrs_pkg::popcount8(byte_data);
    res.pop_low = sbrs_pkg::popcount8(byte_data & low_mask);
    res.bit_set = byte_data[bit_pos];
    res.sel_pos = sbrs_pkg::select8(byte_data, k);
  end

endmodule

// ===== src/sbrs_map.sv =====
module sbrs_map (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         mark_en,
  input  logic [sbrs_pkg::BYTE_AW-1:0] mark_byte,
  input  logic                   [2:0] mark_bit,
  input  logic [sbrs_pkg::BYTE_AW-1:0] rd_byte,
  output logic                   [7:0] rd_data
);

  logic [7:0] map_r [sbrs_pkg::MAP_BYTES];

  // Bitmap storage: cleared by reset or the clear command
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < sbrs_pkg::MAP_BYTES; i++) begin
        map_r[i] <= 8'd0;
      end
    end else if (mark_en) begin
      map_r[mark_byte][mark_bit] <= 1'b1;
    end
  end

  assign rd_data = map_r[rd_byte];

endmodule

// ===== src/station_bitmap_rank_select_top.sv =====
// Station bitmap with rank and select.
// Input channel in_valid/in_stall/in_data carries one command beat: clear,
// mark a point, select the nth saved point, or rank a point. Each command
// gives exactly one result beat on out_valid/out_stall/out_data holding
// found, point_index, rank and the saved count limited to max_stations.
// cfg_wr_en/cfg_wr_data write max_stations (reset value 255); the user writes
// it only while idle, which the block itself does not enforce. Clear and mark
// update the map at the edge that takes the command. A sequencer then walks
// the map one byte per cycle through a single shared byte unit (popcount,
// masked popcount, in-byte select), accumulating the running count over all
// MAP_BYTES bytes. The write state then loads the output register and
// out_valid rises. in_stall is high from acceptance until the result is
// loaded, so no new command is taken while one is in progress.
// The output register holds a result while out_stall is high; the next
// command may be taken meanwhile, and its walk waits in the load cycle until
// the held result is taken. Reset (rst_n low, synchronous) clears the map,
// the sequencer and out_valid, and sets max_stations to 255.
module station_bitmap_rank_select_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic          [7:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbrs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sbrs_pkg::out_beat_t out_data
);

  localparam int AW = sbrs_pkg::BYTE_AW;

  sbrs_pkg::state_t    state_r, state_nxt;
  logic          [7:0] max_r;
  logic          [1:0] cmd_r;
  logic          [7:0] point_r, nth_r;
  logic                point_ok_r;
  logic       [AW-1:0] byte_idx_r, byte_idx_nxt;
  logic          [8:0] cnt_r, cnt_nxt;
  logic                found_r, found_nxt;
  logic          [7:0] pidx_r, pidx_nxt;
  logic          [7:0] rank_r, rank_nxt;
  logic                out_valid_r;
  sbrs_pkg::out_beat_t out_r;

  logic                accept, point_ok, slot_free, last_byte;
  logic                scan_en, load_out;
  logic          [7:0] byte_data;
  logic          [8:0] sel_diff, rank_sum;
  logic                sel_hit;
  sbrs_pkg::byte_res_t bres;

  assign accept    = in_valid && !in_stall;
  assign point_ok  = {1'b0, in_data.point} < 9'(sbrs_pkg::MAP_POINTS);
  assign slot_free = !out_valid_r || !out_stall;
  assign last_byte = byte_idx_r == AW'(sbrs_pkg::MAP_BYTES - 1);

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 8'hff;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  // Map storage; clear and mark act at acceptance
  sbrs_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (accept && in_data.cmd == sbrs_pkg::CMD_CLEAR),
    .mark_en   (accept && in_data.cmd == sbrs_pkg::CMD_MARK && point_ok),
    .mark_byte (in_data.point[3 +: AW]),
    .mark_bit  (in_data.point[2:0]),
    .rd_byte   (byte_idx_r),
    .rd_data   (byte_data)
  );

  // Shared byte unit
  assign sel_diff = {1'b0, nth_r} - cnt_r;

  sbrs_byte_unit u_unit (
    .byte_data (byte_data),
    .bit_pos   (point_r[2:0]),
    .k         (sel_diff[3:0]),
    .res       (bres)
  );

  assign sel_hit  = !found_r && nth_r != 8'd0 && {1'b0, nth_r} > cnt_r &&
                    sel_diff <= {5'd0, bres.pop};
  assign rank_sum = cnt_r + {5'd0, bres.pop_low};

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbrs_pkg::S_IDLE:  if (accept) state_nxt = sbrs_pkg::S_SCAN;
      sbrs_pkg::S_SCAN:  if (last_byte) state_nxt = sbrs_pkg::S_WRITE;
      sbrs_pkg::S_WRITE: if (slot_free) state_nxt = sbrs_pkg::S_IDLE;
      default:           state_nxt = sbrs_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall = 1'b1;
    scan_en  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      sbrs_pkg::S_IDLE:  in_stall = 1'b0;
      sbrs_pkg::S_SCAN:  scan_en  = 1'b1;
      sbrs_pkg::S_WRITE: load_out = slot_free;
      default:           in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbrs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Per-byte accumulation
  always_comb begin
    byte_idx_nxt = byte_idx_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    pidx_nxt     = pidx_r;
    rank_nxt     = rank_r;
    if (accept) begin
      byte_idx_nxt = '0;
      cnt_nxt      = 9'd0;
      found_nxt    = 1'b0;
      pidx_nxt     = sbrs_pkg::NO_POINT;
      rank_nxt     = (in_data.cmd == sbrs_pkg::CMD_RANK) ? in_data.current_rank : 8'd0;
    end else if (scan_en) begin
      byte_idx_nxt = byte_idx_r + AW'(1);
      cnt_nxt      = cnt_r + {5'd0, bres.pop};
      unique case (cmd_r) inside
        sbrs_pkg::CMD_SELECT: begin
          if (sel_hit) begin
            found_nxt = 1'b1;
            pidx_nxt  = 8'({byte_idx_r, bres.sel_pos});
          end
        end
        sbrs_pkg::CMD_RANK: begin
          if (point_ok_r && byte_idx_r == point_r[3 +: AW] && bres.bit_set) begin
            found_nxt = 1'b1;
            rank_nxt  = rank_sum[7:0];
          end
        end
        sbrs_pkg::CMD_CLEAR, sbrs_pkg::CMD_MARK: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    byte_idx_r <= byte_idx_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    pidx_r     <= pidx_nxt;
    rank_r     <= rank_nxt;
    if (accept) begin
      cmd_r      <= in_data.cmd;
      point_r    <= in_data.point;
      nth_r      <= in_data.nth;
      point_ok_r <= point_ok;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.found       <= found_r;
      out_r.point_index <= pidx_r;
      out_r.rank        <= rank_r;
      out_r.total       <= (cnt_r > {1'b0, max_r}) ? max_r : cnt_r[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == sbrs_pkg::S_SCAN)
    else $error("accepted beat did not start a walk");

  a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sbrs_pkg::S_WRITE))
    else $error("result appeared outside the load cycle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sbrs_pkg::S_SCAN |-> cnt_r <= {byte_idx_r, 3'b000})
    else $error("running count exceeds bits walked");

  a_select_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbrs_pkg::S_WRITE && cmd_r == sbrs_pkg::CMD_SELECT && found_r)
      |-> nth_r != 8'd0 && cnt_r >= {1'b0, nth_r})
    else $error("select hit inconsistent with count");

endmodule

// ===== verif/station_map_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each result beat from
// a private copy of the station map and compares it with what the block gives.
module station_map_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic          [7:0] cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sbrs_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sbrs_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  pending
);

  localparam int MAP_LIMIT = (sbrs_pkg::MAP_POINTS > 256) ? 256 : sbrs_pkg::MAP_POINTS;

  logic [255:0]        saved_map;
  logic   [7:0]        limit_copy;
  sbrs_pkg::out_beat_t awaited_results[$];
  sbrs_pkg::out_beat_t want;
  int                  errors = 0;

  // Applies one command to the private map and returns the result beat it gives
  function automatic sbrs_pkg::out_beat_t predict_station_result(input sbrs_pkg::in_beat_t b);
    sbrs_pkg::out_beat_t r;
    int                  cnt;
    r.found       = 1'b0;
    r.point_index = sbrs_pkg::NO_POINT;
    r.rank        = 8'd0;
    case (b.cmd)
      sbrs_pkg::CMD_CLEAR: begin
        saved_map = '0;
      end
      sbrs_pkg::CMD_MARK: begin
        if (int'(b.point) < MAP_LIMIT) saved_map[b.point] = 1'b1;
      end
      sbrs_pkg::CMD_SELECT: begin
        // ascending scan; nth of zero never matches
        cnt = 0;
        for (int i = 0; i < MAP_LIMIT; i++) begin
          if (saved_map[i] && !r.found) begin
            cnt++;
            if (cnt == int'(b.nth)) begin
              r.found       = 1'b1;
              r.point_index = 8'(i);
            end
          end
        end
      end
      sbrs_pkg::CMD_RANK: begin
        r.rank = b.current_rank;
        if (int'(b.point) < MAP_LIMIT && saved_map[b.point]) begin
          cnt = 0;
          for (int i = 0; i <= int'(b.point); i++) cnt += int'(saved_map[i]);
          r.found = 1'b1;
          r.rank  = 8'(cnt);  // a rank of 256 wraps to 0
        end
      end
    endcase
    // full-width count, then limited
    cnt = 0;
    for (int i = 0; i < MAP_LIMIT; i++) cnt += int'(saved_map[i]);
    r.total = (cnt > int'(limit_copy)) ? limit_copy : 8'(cnt);
    return r;
  endfunction

  // Result side first, so a beat never matches an expectation queued at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      saved_map  = '0;
      limit_copy = 8'd255;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat with nothing awaited: %s%0b %s%0d %s%0d %s%0d",
                     $realtime, "found=", out_data.found,
                     "point_index=", out_data.point_index, "rank=", out_data.rank,
                     "total=", out_data.total);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.found !== want.found || out_data.point_index !== want.point_index ||
              out_data.rank !== want.rank || out_data.total !== want.total) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch: expected found=%0b point_index=%0d rank=%0d total=%0d",
                       $realtime, want.found, want.point_index, want.rank, want.total);
              $display("%0t:           got      found=%0b point_index=%0d rank=%0d total=%0d",
                       $realtime, out_data.found, out_data.point_index, out_data.rank,
                       out_data.total);
            end
          end
        end
      end
      if (cfg_wr_en) limit_copy = cfg_wr_data;
      if (in_valid && !in_stall) awaited_results.push_back(predict_station_result(in_data));
    end
    fail_count <= errors;
    pending    <= awaited_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic          [7:0] cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  sbrs_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  sbrs_pkg::out_beat_t out_data;
  int                  fail_count;
  int                  pending;

  // Points the stimulus has marked since the last clear; only steers queries
  logic [255:0] hot_map = '0;
  int           hot_count = 0;
  bit           calm = 1'b0;

  station_bitmap_rank_select_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  station_map_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 200);
  endfunction

  // Sends one command beat and returns at the edge that takes it; valid stays up
  task automatic issue_command(input logic [1:0] cmd, input logic [7:0] pt,
                               input logic [7:0] nth, input logic [7:0] cur);
    sbrs_pkg::in_beat_t beat;
    int                 gap;
    beat.cmd          = cmd;
    beat.point        = pt;
    beat.nth          = nth;
    beat.current_rank = cur;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    if (cmd == sbrs_pkg::CMD_CLEAR) begin
      hot_map   = '0;
      hot_count = 0;
    end else if (cmd == sbrs_pkg::CMD_MARK && !hot_map[pt]) begin
      hot_map[pt] = 1'b1;
      hot_count++;
    end
  endtask

  // Drops valid and waits until every result beat has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_limit(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random mix; selects and ranks lean toward the saved points
  task automatic random_commands(input int count);
    int         r;
    logic [7:0] pt;
    logic [7:0] nth;
    for (int k = 0; k < count; k++) begin
      r   = $urandom_range(0, 99);
      pt  = 8'($urandom);
      nth = 8'($urandom);
      if (r < 1) begin
        issue_command(sbrs_pkg::CMD_CLEAR, pt, nth, 8'($urandom));
      end else if (r < 48) begin
        issue_command(sbrs_pkg::CMD_MARK, pt, nth, 8'($urandom));
      end else if (r < 73) begin
        if (hot_count > 0 && $urandom_range(0, 1) == 1)
          nth = 8'($urandom_range(0, (hot_count > 253) ? 255 : hot_count + 2));
        issue_command(sbrs_pkg::CMD_SELECT, pt, nth, 8'($urandom));
      end else begin
        if (hot_count > 0 && $urandom_range(0, 2) != 0)
          while (!hot_map[pt]) pt = 8'($urandom);
        issue_command(sbrs_pkg::CMD_RANK, pt, nth, 8'($urandom));
      end
    end
  endtask

  // Result side stalls: short bursts of stall between free runs, now and then a long free run
  initial begin : result_side
    int run;
    int hold;
    out_stall <= 1'b0;
    forever begin
      if ($urandom_range(0, 24) == 0) run = $urandom_range(150, 500);
      else run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      hold = idle_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int         fill_order[256];
    int         j;
    int         tmp;
    logic [7:0] lim;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 8'd0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_limit(8'd255);

    // Directed: empty map, ends of the point range, duplicates, no-match cases
    issue_command(sbrs_pkg::CMD_SELECT, 8'h00, 8'h00, 8'h00);
    issue_command(sbrs_pkg::CMD_SELECT, 8'hff, 8'h01, 8'hff);
    issue_command(sbrs_pkg::CMD_RANK,   8'h00, 8'h00, 8'ha5);
    issue_command(sbrs_pkg::CMD_MARK,   8'h00, 8'hff, 8'hff);
    issue_command(sbrs_pkg::CMD_MARK,   8'hff, 8'h00, 8'h00);
    issue_command(sbrs_pkg::CMD_MARK,   8'h80, 8'h7f, 8'h80);
    issue_command(sbrs_pkg::CMD_MARK,   8'h80, 8'h80, 8'h7f);
    issue_command(sbrs_pkg::CMD_SELECT, 8'h00, 8'h01, 8'h00);
    issue_command(sbrs_pkg::CMD_SELECT, 8'h00, 8'h03, 8'h00);
    issue_command(sbrs_pkg::CMD_SELECT, 8'hff, 8'h04, 8'hff);
    issue_command(sbrs_pkg::CMD_SELECT, 8'hff, 8'hff, 8'hff);
    issue_command(sbrs_pkg::CMD_SELECT, 8'h80, 8'h00, 8'h80);
    issue_command(sbrs_pkg::CMD_RANK,   8'h00, 8'hff, 8'h5a);
    issue_command(sbrs_pkg::CMD_RANK,   8'hff, 8'h00, 8'h00);
    issue_command(sbrs_pkg::CMD_RANK,   8'h7f, 8'h00, 8'hff);
    issue_command(sbrs_pkg::CMD_RANK,   8'h80, 8'hff, 8'h00);
    issue_command(sbrs_pkg::CMD_CLEAR,  8'hff, 8'hff, 8'hff);
    issue_command(sbrs_pkg::CMD_RANK,   8'h80, 8'h01, 8'h33);
    issue_command(sbrs_pkg::CMD_MARK,   8'h55, 8'haa, 8'h55);
    issue_command(sbrs_pkg::CMD_MARK,   8'haa, 8'h55, 8'haa);
    // count above a limit of one
    wait_idle();
    set_limit(8'd1);
    issue_command(sbrs_pkg::CMD_RANK,   8'haa, 8'h00, 8'h00);
    issue_command(sbrs_pkg::CMD_SELECT, 8'h00, 8'h02, 8'h00);
    issue_command(sbrs_pkg::CMD_MARK,   8'h0f, 8'hf0, 8'h0f);
    issue_command(sbrs_pkg::CMD_CLEAR,  8'h00, 8'h00, 8'h00);

    // Full map in shuffled order: rank of the last point wraps, total saturates
    wait_idle();
    set_limit(8'd255);
    issue_command(sbrs_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 256; i++) fill_order[i] = i;
    for (int i = 255; i > 0; i--) begin
      j             = $urandom_range(0, i);
      tmp           = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    calm = 1'b1;
    for (int i = 0; i < 256; i++)
      issue_command(sbrs_pkg::CMD_MARK, 8'(fill_order[i]), 8'($urandom), 8'($urandom));
    calm = 1'b0;
    issue_command(sbrs_pkg::CMD_RANK,   8'hff, 8'($urandom), 8'($urandom));
    issue_command(sbrs_pkg::CMD_RANK,   8'h00, 8'($urandom), 8'($urandom));
    issue_command(sbrs_pkg::CMD_SELECT, 8'($urandom), 8'hff, 8'($urandom));
    issue_command(sbrs_pkg::CMD_SELECT, 8'($urandom), 8'h00, 8'($urandom));
    random_commands(16);
    wait_idle();
    set_limit(8'd0);
    random_commands(12);
    wait_idle();
    set_limit(8'd128);
    random_commands(12);

    // Random phases, one limit setting each
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: lim = 8'd0;
        1: lim = 8'd255;
        2: lim = 8'd1;
        3: lim = 8'd40;
        6: lim = 8'd200;
        7: lim = 8'd255;
        default: lim = 8'($urandom);
      endcase
      wait_idle();
      set_limit(lim);
      calm = ($urandom_range(0, 3) == 0);
      random_commands(200);
    end
    calm = 1'b0;

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #100ms;
    $display("Verification failed");
    $finish;
  end

endmodule
